>>> rtl/core/one_wire_bus_master_assert.svh
// ----------------------------------------------------------------------------
// One-wire bus master assertion macros
// Concurrent check macros shared by the RTL; they compile to nothing when
// ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk and disabled during reset.
`define OWBM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("one-wire bus master: same-cycle check failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define OWBM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("one-wire bus master: next-cycle check failed");
`else
`define OWBM_ASSERT_NOW(label, ante, cons)
`define OWBM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/core/owbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-wire bus master package
// Shared widths, item kind codes, register indexes and bundle types.
// ----------------------------------------------------------------------------
package owbm_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
	localparam int CNT_W         = 10;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 10;

	// Item kind codes.
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_RESET = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_WAIT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOV  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_START   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_HOLD    = 3'd4;

	// Timing register bundle.
	typedef struct packed {
		logic [9:0] reset_low_ticks;
		logic [9:0] presence_wait_ticks;
		logic [9:0] reset_recover_ticks;
		logic [3:0] slot_start_ticks;
		logic [7:0] slot_hold_ticks;
	} cfg_t;

	// One result beat.
	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence_missing;
		logic [7:0] read_data;
		logic       rejected;
	} result_t;

endpackage

>>> rtl/core/owbm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-wire bus master timing registers
// Holds the five tick-count registers written through the plain write port.
// ----------------------------------------------------------------------------
module owbm_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [owbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [owbm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output owbm_pkg::cfg_t                 cfg
);

	owbm_pkg::cfg_t cfg_q;

	// Register writes; out-of-range indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks     <= 10'd480;
			cfg_q.presence_wait_ticks <= 10'd60;
			cfg_q.reset_recover_ticks <= 10'd420;
			cfg_q.slot_start_ticks    <= 4'd2;
			cfg_q.slot_hold_ticks     <= 8'd60;
		end else if (cfg_we) begin
			case (cfg_index)
				owbm_pkg::REG_RESET_LOW:   cfg_q.reset_low_ticks     <= cfg_wdata;
				owbm_pkg::REG_PRES_WAIT:   cfg_q.presence_wait_ticks <= cfg_wdata;
				owbm_pkg::REG_RESET_RECOV: cfg_q.reset_recover_ticks <= cfg_wdata;
				owbm_pkg::REG_SLOT_START:  cfg_q.slot_start_ticks    <= cfg_wdata[3:0];
				owbm_pkg::REG_SLOT_HOLD:   cfg_q.slot_hold_ticks     <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/owbm_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-wire bus master sequencer
// Bus state machine: reset pulse, presence sample and byte slots. It takes
// one item per step and gives the result beat of that step.
// ----------------------------------------------------------------------------
module owbm_fsm (
	input  logic                  clk,
	input  logic                  arst_n,
	input  owbm_pkg::cfg_t        cfg,
	input  logic                  step,
	input  logic [1:0]            kind,
	input  logic [7:0]            data_byte,
	input  logic                  line_level,
	output owbm_pkg::result_t     res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_RST_WAIT,
		PH_RST_RECOVER,
		PH_SLOT_START,
		PH_SLOT_HOLD
	} phase_t;

	phase_t                             phase_q, phase_d;
	logic [1:0]                         op_q, op_d;
	logic [owbm_pkg::CNT_W-1:0]         cnt_q, cnt_d;
	logic [owbm_pkg::BIT_IDX_W-1:0]     bit_q, bit_d;
	logic [7:0]                         shift_q, shift_d;
	logic                               pres_q, pres_d;
	logic                               line_q, line_d;
	logic [7:0]                         rdlat_q, rdlat_d;
	logic                               done, rej;
	logic [owbm_pkg::CNT_W-1:0]         cnt_inc;
	logic [owbm_pkg::CNT_W-1:0]         limit;
	logic                               expire;
	logic [7:0]                         shift_smp;

	// Phase length and tick counter compare.
	always_comb begin
		case (phase_q)
			PH_RST_LOW:     limit = cfg.reset_low_ticks;
			PH_RST_WAIT:    limit = cfg.presence_wait_ticks;
			PH_RST_RECOVER: limit = cfg.reset_recover_ticks;
			PH_SLOT_START:  limit = owbm_pkg::CNT_W'(cfg.slot_start_ticks);
			PH_SLOT_HOLD:   limit = owbm_pkg::CNT_W'(cfg.slot_hold_ticks);
			default:        limit = '0;
		endcase
	end

	assign cnt_inc = cnt_q + 1'b1;
	assign expire  = (cnt_inc >= limit);

	// A read slot samples the line on the first tick of its hold part.
	assign shift_smp = (op_q == owbm_pkg::KIND_READ && cnt_q == '0) ?
		{line_level, shift_q[7:1]} : shift_q;

	// Next-state logic for one item.
	always_comb begin
		phase_d = phase_q;
		op_d    = op_q;
		cnt_d   = cnt_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		pres_d  = pres_q;
		line_d  = line_q;
		rdlat_d = rdlat_q;
		done    = 1'b0;
		rej     = 1'b0;
		if (kind != owbm_pkg::KIND_TICK) begin
			if (phase_q != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				op_d   = kind;
				cnt_d  = '0;
				bit_d  = '0;
				line_d = 1'b1;
				if (kind == owbm_pkg::KIND_RESET) begin
					phase_d = PH_RST_LOW;
				end else begin
					phase_d = PH_SLOT_START;
					shift_d = (kind == owbm_pkg::KIND_WRITE) ? data_byte : 8'd0;
				end
			end
		end else begin
			case (phase_q)
				PH_IDLE: ;
				PH_RST_LOW: begin
					cnt_d = cnt_inc;
					if (expire) begin
						line_d  = 1'b0;
						phase_d = PH_RST_WAIT;
						cnt_d   = '0;
					end
				end
				PH_RST_WAIT: begin
					cnt_d = cnt_inc;
					if (expire) begin
						pres_d  = line_level;
						phase_d = PH_RST_RECOVER;
						cnt_d   = '0;
					end
				end
				PH_RST_RECOVER: begin
					cnt_d = cnt_inc;
					if (expire) begin
						phase_d = PH_IDLE;
						cnt_d   = '0;
						done    = 1'b1;
					end
				end
				PH_SLOT_START: begin
					cnt_d = cnt_inc;
					if (expire) begin
						line_d  = (op_q == owbm_pkg::KIND_WRITE) ? ~shift_q[0] : 1'b0;
						phase_d = PH_SLOT_HOLD;
						cnt_d   = '0;
					end
				end
				PH_SLOT_HOLD: begin
					cnt_d   = cnt_inc;
					shift_d = shift_smp;
					if (expire) begin
						line_d = 1'b0;
						if (op_q == owbm_pkg::KIND_WRITE) begin
							shift_d = {1'b0, shift_smp[7:1]};
						end
						if (bit_q == owbm_pkg::BIT_IDX_W'(owbm_pkg::BITS_PER_BYTE - 1)) begin
							if (op_q == owbm_pkg::KIND_READ) begin
								rdlat_d = shift_smp;
							end
							phase_d = PH_IDLE;
							cnt_d   = '0;
							bit_d   = '0;
							done    = 1'b1;
						end else begin
							bit_d   = bit_q + 1'b1;
							phase_d = PH_SLOT_START;
							line_d  = 1'b1;
							cnt_d   = '0;
						end
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// State update, one item per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			op_q    <= '0;
			cnt_q   <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			pres_q  <= 1'b1;
			line_q  <= 1'b0;
			rdlat_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			op_q    <= op_d;
			cnt_q   <= cnt_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			pres_q  <= pres_d;
			line_q  <= line_d;
			rdlat_q <= rdlat_d;
		end
	end

	// Result beat reflects the state after this step.
	assign res.drive_low        = line_d;
	assign res.busy_res         = (phase_d != PH_IDLE);
	assign res.done_res         = done;
	assign res.presence_missing = pres_d;
	assign res.read_data        = rdlat_d;
	assign res.rejected         = rej;

endmodule

>>> rtl/core/one_wire_bus_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// One-wire bus master
// Command and tick driven single-wire bus master with an input register,
// a sequencer step and a result register.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  in       in_valid / in_ready    kind, data_byte, line_level
//  out      out_valid / out_ready  drive_low, busy_res, done_res,
//                                  presence_missing, read_data, rejected
//  cfg      cfg_we                 cfg_index, cfg_wdata
//
// Every input beat yields one result beat through the input register, the single
// sequencer step and the result register; one beat is taken per cycle unless the output stalls.
// Reset clears the state and loads the default tick counts.
// A stalled output holds its beat while the input register still takes one
// more beat; after that, in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module one_wire_bus_master (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [owbm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      kind,
	input  logic [7:0]                      data_byte,
	input  logic                            line_level,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            drive_low,
	output logic                            busy_res,
	output logic                            done_res,
	output logic                            presence_missing,
	output logic [7:0]                      read_data,
	output logic                            rejected
);

	owbm_pkg::cfg_t    cfg;
	owbm_pkg::result_t res;
	owbm_pkg::result_t res_q;
	logic              valid_s1;
	logic [1:0]        kind_s1;
	logic [7:0]        data_s1;
	logic              level_s1;
	logic              out_valid_q;
	logic              out_free;
	logic              step;

	owbm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	// Flow control across the two registers.
	assign out_free = !out_valid_q || out_ready;
	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1  <= kind;
			data_s1  <= data_byte;
			level_s1 <= line_level;
		end
	end

	owbm_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.kind      (kind_s1),
		.data_byte (data_s1),
		.line_level(level_s1),
		.res       (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign drive_low        = res_q.drive_low;
	assign busy_res         = res_q.busy_res;
	assign done_res         = res_q.done_res;
	assign presence_missing = res_q.presence_missing;
	assign read_data        = res_q.read_data;
	assign rejected         = res_q.rejected;

	// Checks on the sequencer and the pipeline.
`include "one_wire_bus_master_assert.svh"
	`OWBM_ASSERT_NOW(a_idle_released, out_valid_q && !res_q.busy_res, !res_q.drive_low)
	`OWBM_ASSERT_NOW(a_done_idle, out_valid_q && res_q.done_res, !res_q.busy_res)
	`OWBM_ASSERT_NOW(a_reject_busy, out_valid_q && res_q.rejected,
		res_q.busy_res && !res_q.done_res)
	`OWBM_ASSERT_NEXT(a_s1_held, valid_s1 && !out_free, valid_s1)

endmodule
